FILE: hw/rtl/k2r_pkg.sv
// Package: romaji tables, lookup functions and shared types for the kana converter.
package k2r_pkg;

    localparam logic [15:0] KANA_LO    = 16'h30A1;
    localparam logic [15:0] KANA_HI    = 16'h30FC;
    localparam logic [15:0] MIDDOT     = 16'h30FB;
    localparam logic [15:0] SMALL_TSU  = 16'h30C3;
    localparam logic [15:0] HIRA_LO    = 16'h3041;
    localparam logic [15:0] HIRA_HI    = 16'h3093;
    localparam logic [15:0] HIRA_SHIFT = 16'h0060;

    // Up to three ASCII letters; len 0..3
    typedef struct packed {
        logic [1:0]  len;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } t_rom;

    // Single-kana entry: hit=0 means no entry
    typedef struct packed {
        logic hit;
        t_rom rom;
    } t_single;

    // Result of converting one held character
    typedef struct packed {
        logic [2:0]  cnt;      // beats produced (0..3)
        logic        copy;     // beat 0 is the held character itself
        logic        pair;     // lookahead consumed too
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } t_chunk;

    function automatic t_rom mk(input logic [1:0] n, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] c);
        t_rom r;
        r.len = n; r.c0 = a; r.c1 = b; r.c2 = c;
        return r;
    endfunction

    function automatic logic [15:0] fold(input logic [15:0] ch);
        logic [15:0] r;
        r = ch;
        if (ch >= HIRA_LO && ch <= HIRA_HI) r = ch + HIRA_SHIFT;
        return r;
    endfunction

    function automatic t_single single_rom(input logic [15:0] ch);
        t_single s;
        s.hit = 1'b1;
        s.rom = mk(2'd0, 8'd0, 8'd0, 8'd0);
        case (ch)
            16'h30A1, 16'h30A2: s.rom = mk(2'd1, "a", 0, 0);
            16'h30A3, 16'h30A4: s.rom = mk(2'd1, "i", 0, 0);
            16'h30A5, 16'h30A6: s.rom = mk(2'd1, "u", 0, 0);
            16'h30A7, 16'h30A8: s.rom = mk(2'd1, "e", 0, 0);
            16'h30A9, 16'h30AA: s.rom = mk(2'd1, "o", 0, 0);
            16'h30AB: s.rom = mk(2'd2, "k", "a", 0);
            16'h30AC: s.rom = mk(2'd2, "g", "a", 0);
            16'h30AD: s.rom = mk(2'd2, "k", "i", 0);
            16'h30AE: s.rom = mk(2'd2, "g", "i", 0);
            16'h30AF: s.rom = mk(2'd2, "k", "u", 0);
            16'h30B0: s.rom = mk(2'd2, "g", "u", 0);
            16'h30B1: s.rom = mk(2'd2, "k", "e", 0);
            16'h30B2: s.rom = mk(2'd2, "g", "e", 0);
            16'h30B3: s.rom = mk(2'd2, "k", "o", 0);
            16'h30B4: s.rom = mk(2'd2, "g", "o", 0);
            16'h30B5: s.rom = mk(2'd2, "s", "a", 0);
            16'h30B6: s.rom = mk(2'd2, "z", "a", 0);
            16'h30B7: s.rom = mk(2'd3, "s", "h", "i");
            16'h30B8: s.rom = mk(2'd2, "j", "i", 0);
            16'h30B9: s.rom = mk(2'd2, "s", "u", 0);
            16'h30BA: s.rom = mk(2'd2, "z", "u", 0);
            16'h30BB: s.rom = mk(2'd2, "s", "e", 0);
            16'h30BC: s.rom = mk(2'd2, "z", "e", 0);
            16'h30BD: s.rom = mk(2'd2, "s", "o", 0);
            16'h30BE: s.rom = mk(2'd2, "z", "o", 0);
            16'h30BF: s.rom = mk(2'd2, "t", "a", 0);
            16'h30C0: s.rom = mk(2'd2, "d", "a", 0);
            16'h30C1: s.rom = mk(2'd3, "c", "h", "i");
            16'h30C2: s.rom = mk(2'd2, "j", "i", 0);
            16'h30C3: s.hit = 1'b0;
            16'h30C4: s.rom = mk(2'd3, "t", "s", "u");
            16'h30C5: s.rom = mk(2'd3, "d", "z", "u");
            16'h30C6: s.rom = mk(2'd2, "t", "e", 0);
            16'h30C7: s.rom = mk(2'd2, "d", "e", 0);
            16'h30C8: s.rom = mk(2'd2, "t", "o", 0);
            16'h30C9: s.rom = mk(2'd2, "d", "o", 0);
            16'h30CA: s.rom = mk(2'd2, "n", "a", 0);
            16'h30CB: s.rom = mk(2'd2, "n", "i", 0);
            16'h30CC: s.rom = mk(2'd2, "n", "u", 0);
            16'h30CD: s.rom = mk(2'd2, "n", "e", 0);
            16'h30CE: s.rom = mk(2'd2, "n", "o", 0);
            16'h30CF: s.rom = mk(2'd2, "h", "a", 0);
            16'h30D0: s.rom = mk(2'd2, "b", "a", 0);
            16'h30D1: s.rom = mk(2'd2, "p", "a", 0);
            16'h30D2: s.rom = mk(2'd2, "h", "i", 0);
            16'h30D3: s.rom = mk(2'd2, "b", "i", 0);
            16'h30D4: s.rom = mk(2'd2, "p", "i", 0);
            16'h30D5: s.rom = mk(2'd2, "f", "u", 0);
            16'h30D6: s.rom = mk(2'd2, "b", "u", 0);
            16'h30D7: s.rom = mk(2'd2, "p", "u", 0);
            16'h30D8: s.rom = mk(2'd2, "h", "e", 0);
            16'h30D9: s.rom = mk(2'd2, "b", "e", 0);
            16'h30DA: s.rom = mk(2'd2, "p", "e", 0);
            16'h30DB: s.rom = mk(2'd2, "h", "o", 0);
            16'h30DC: s.rom = mk(2'd2, "b", "o", 0);
            16'h30DD: s.rom = mk(2'd2, "p", "o", 0);
            16'h30DE: s.rom = mk(2'd2, "m", "a", 0);
            16'h30DF: s.rom = mk(2'd2, "m", "i", 0);
            16'h30E0: s.rom = mk(2'd2, "m", "u", 0);
            16'h30E1: s.rom = mk(2'd2, "m", "e", 0);
            16'h30E2: s.rom = mk(2'd2, "m", "o", 0);
            16'h30E3, 16'h30E4: s.rom = mk(2'd2, "y", "a", 0);
            16'h30E5, 16'h30E6: s.rom = mk(2'd2, "y", "u", 0);
            16'h30E7, 16'h30E8: s.rom = mk(2'd2, "y", "o", 0);
            16'h30E9: s.rom = mk(2'd2, "r", "a", 0);
            16'h30EA: s.rom = mk(2'd2, "r", "i", 0);
            16'h30EB: s.rom = mk(2'd2, "r", "u", 0);
            16'h30EC: s.rom = mk(2'd2, "r", "e", 0);
            16'h30ED: s.rom = mk(2'd2, "r", "o", 0);
            16'h30EE, 16'h30EF: s.rom = mk(2'd2, "w", "a", 0);
            16'h30F0: s.rom = mk(2'd2, "w", "i", 0);
            16'h30F1: s.rom = mk(2'd2, "w", "e", 0);
            16'h30F2: s.rom = mk(2'd2, "w", "o", 0);
            16'h30F3: s.rom = mk(2'd1, "n", 0, 0);
            16'h30F4: s.rom = mk(2'd2, "v", "u", 0);
            16'h30FC: s.rom = mk(2'd0, 0, 0, 0);   // long-vowel mark: empty
            default:  s.hit = 1'b0;
        endcase
        return s;
    endfunction

    // Digraph table; lookup keyed on lead/trail pair (entries are unique)
    function automatic t_single pair_rom(input logic [15:0] a, input logic [15:0] b);
        t_single s;
        s.hit = 1'b1;
        s.rom = mk(2'd0, 8'd0, 8'd0, 8'd0);
        case ({a, b})
            {16'h30AD,16'h30E3}: s.rom = mk(2'd3,"k","y","a");
            {16'h30AD,16'h30E5}: s.rom = mk(2'd3,"k","y","u");
            {16'h30AD,16'h30E7}: s.rom = mk(2'd3,"k","y","o");
            {16'h30B7,16'h30E3}: s.rom = mk(2'd3,"s","h","a");
            {16'h30B7,16'h30E5}: s.rom = mk(2'd3,"s","h","u");
            {16'h30B7,16'h30E7}: s.rom = mk(2'd3,"s","h","o");
            {16'h30C1,16'h30E3}: s.rom = mk(2'd3,"c","h","a");
            {16'h30C1,16'h30E5}: s.rom = mk(2'd3,"c","h","u");
            {16'h30C1,16'h30E7}: s.rom = mk(2'd3,"c","h","o");
            {16'h30CB,16'h30E3}: s.rom = mk(2'd3,"n","y","a");
            {16'h30CB,16'h30E5}: s.rom = mk(2'd3,"n","y","u");
            {16'h30CB,16'h30E7}: s.rom = mk(2'd3,"n","y","o");
            {16'h30D2,16'h30E3}: s.rom = mk(2'd3,"h","y","a");
            {16'h30D2,16'h30E5}: s.rom = mk(2'd3,"h","y","u");
            {16'h30D2,16'h30E7}: s.rom = mk(2'd3,"h","y","o");
            {16'h30DF,16'h30E3}: s.rom = mk(2'd3,"m","y","a");
            {16'h30DF,16'h30E5}: s.rom = mk(2'd3,"m","y","u");
            {16'h30DF,16'h30E7}: s.rom = mk(2'd3,"m","y","o");
            {16'h30EA,16'h30E3}: s.rom = mk(2'd3,"r","y","a");
            {16'h30EA,16'h30E5}: s.rom = mk(2'd3,"r","y","u");
            {16'h30EA,16'h30E7}: s.rom = mk(2'd3,"r","y","o");
            {16'h30F0,16'h30E3}: s.rom = mk(2'd3,"w","y","a");
            {16'h30F0,16'h30E5}: s.rom = mk(2'd3,"w","y","u");
            {16'h30F0,16'h30E7}: s.rom = mk(2'd3,"w","y","o");
            {16'h30AE,16'h30E3}: s.rom = mk(2'd3,"g","y","a");
            {16'h30AE,16'h30E5}: s.rom = mk(2'd3,"g","y","u");
            {16'h30AE,16'h30E7}: s.rom = mk(2'd3,"g","y","o");
            {16'h30B8,16'h30E3}: s.rom = mk(2'd2,"j","a",0);
            {16'h30B8,16'h30E5}: s.rom = mk(2'd2,"j","u",0);
            {16'h30B8,16'h30E7}: s.rom = mk(2'd2,"j","o",0);
            {16'h30C2,16'h30E3}: s.rom = mk(2'd2,"j","a",0);
            {16'h30C2,16'h30E5}: s.rom = mk(2'd2,"j","u",0);
            {16'h30C2,16'h30E7}: s.rom = mk(2'd2,"j","o",0);
            {16'h30D3,16'h30E3}: s.rom = mk(2'd3,"b","y","a");
            {16'h30D3,16'h30E5}: s.rom = mk(2'd3,"b","y","u");
            {16'h30D3,16'h30E7}: s.rom = mk(2'd3,"b","y","o");
            {16'h30D4,16'h30E3}: s.rom = mk(2'd3,"p","y","a");
            {16'h30D4,16'h30E5}: s.rom = mk(2'd3,"p","y","u");
            {16'h30D4,16'h30E7}: s.rom = mk(2'd3,"p","y","o");
            {16'h30A4,16'h30A7}: s.rom = mk(2'd2,"y","e",0);
            {16'h30E6,16'h30A7}: s.rom = mk(2'd2,"y","e",0);
            {16'h30F4,16'h30A1}: s.rom = mk(2'd2,"v","a",0);
            {16'h30F4,16'h30A3}: s.rom = mk(2'd2,"v","i",0);
            {16'h30F4,16'h30A7}: s.rom = mk(2'd2,"v","e",0);
            {16'h30F4,16'h30A9}: s.rom = mk(2'd2,"v","o",0);
            {16'h30F4,16'h30E3}: s.rom = mk(2'd3,"v","y","a");
            {16'h30F4,16'h30E5}: s.rom = mk(2'd3,"v","y","u");
            {16'h30F4,16'h30E7}: s.rom = mk(2'd3,"v","y","o");
            {16'h30B7,16'h30A7}: s.rom = mk(2'd3,"s","h","e");
            {16'h30B8,16'h30A7}: s.rom = mk(2'd2,"j","e",0);
            {16'h30C1,16'h30A7}: s.rom = mk(2'd3,"c","h","e");
            {16'h30B9,16'h30A3}: s.rom = mk(2'd2,"s","i",0);
            {16'h30B9,16'h30E3}: s.rom = mk(2'd3,"s","y","a");
            {16'h30B9,16'h30E5}: s.rom = mk(2'd3,"s","y","u");
            {16'h30B9,16'h30E7}: s.rom = mk(2'd3,"s","y","o");
            {16'h30BA,16'h30A3}: s.rom = mk(2'd2,"z","i",0);
            {16'h30BA,16'h30E3}: s.rom = mk(2'd3,"z","y","a");
            {16'h30BA,16'h30E5}: s.rom = mk(2'd3,"z","y","u");
            {16'h30BA,16'h30E7}: s.rom = mk(2'd3,"z","y","o");
            {16'h30C6,16'h30A3}: s.rom = mk(2'd2,"t","i",0);
            {16'h30C8,16'h30A5}: s.rom = mk(2'd2,"t","u",0);
            {16'h30C6,16'h30E3}: s.rom = mk(2'd3,"t","y","a");
            {16'h30C6,16'h30E5}: s.rom = mk(2'd3,"t","y","u");
            {16'h30C6,16'h30E7}: s.rom = mk(2'd3,"t","y","o");
            {16'h30C7,16'h30A3}: s.rom = mk(2'd2,"d","i",0);
            {16'h30C9,16'h30A5}: s.rom = mk(2'd2,"d","u",0);
            {16'h30C7,16'h30E3}: s.rom = mk(2'd3,"d","y","a");
            {16'h30C7,16'h30E5}: s.rom = mk(2'd3,"d","y","u");
            {16'h30C7,16'h30E7}: s.rom = mk(2'd3,"d","y","o");
            {16'h30C4,16'h30A1}: s.rom = mk(2'd3,"t","s","a");
            {16'h30C4,16'h30A3}: s.rom = mk(2'd3,"t","s","i");
            {16'h30C4,16'h30A7}: s.rom = mk(2'd3,"t","s","e");
            {16'h30C4,16'h30A9}: s.rom = mk(2'd3,"t","s","o");
            {16'h30D5,16'h30A1}: s.rom = mk(2'd2,"f","a",0);
            {16'h30D5,16'h30A3}: s.rom = mk(2'd2,"f","i",0);
            {16'h30DB,16'h30A5}: s.rom = mk(2'd2,"h","u",0);
            {16'h30D5,16'h30A7}: s.rom = mk(2'd2,"f","e",0);
            {16'h30D5,16'h30A9}: s.rom = mk(2'd2,"f","o",0);
            {16'h30D5,16'h30E3}: s.rom = mk(2'd3,"f","y","a");
            {16'h30D5,16'h30E5}: s.rom = mk(2'd3,"f","y","u");
            {16'h30D5,16'h30E7}: s.rom = mk(2'd3,"f","y","o");
            {16'h30EA,16'h30A7}: s.rom = mk(2'd3,"r","y","e");
            {16'h30A6,16'h30A1}: s.rom = mk(2'd2,"w","a",0);
            {16'h30A6,16'h30A3}: s.rom = mk(2'd2,"w","i",0);
            {16'h30A6,16'h30A7}: s.rom = mk(2'd2,"w","e",0);
            {16'h30A6,16'h30A9}: s.rom = mk(2'd2,"w","o",0);
            {16'h30A6,16'h30E3}: s.rom = mk(2'd3,"w","y","a");
            {16'h30A6,16'h30E5}: s.rom = mk(2'd3,"w","y","u");
            {16'h30A6,16'h30E7}: s.rom = mk(2'd3,"w","y","o");
            {16'h30AF,16'h30A1}: s.rom = mk(2'd3,"k","w","a");
            {16'h30AF,16'h30EE}: s.rom = mk(2'd3,"k","w","a");
            {16'h30AF,16'h30A3}: s.rom = mk(2'd3,"k","w","i");
            {16'h30AF,16'h30A5}: s.rom = mk(2'd3,"k","w","u");
            {16'h30AF,16'h30A7}: s.rom = mk(2'd3,"k","w","e");
            {16'h30AF,16'h30A9}: s.rom = mk(2'd3,"k","w","o");
            {16'h30B0,16'h30A1}: s.rom = mk(2'd3,"g","w","a");
            {16'h30B0,16'h30EE}: s.rom = mk(2'd3,"g","w","a");
            {16'h30B0,16'h30A3}: s.rom = mk(2'd3,"g","w","i");
            {16'h30B0,16'h30A5}: s.rom = mk(2'd3,"g","w","u");
            {16'h30B0,16'h30A7}: s.rom = mk(2'd3,"g","w","e");
            {16'h30B0,16'h30A9}: s.rom = mk(2'd3,"g","w","o");
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/k2r_stream_if.sv
// Valid/ready stream interface carrying one code unit and an end flag.
interface k2r_stream_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        final_unit;
    logic [15:0] out_unit;
    logic        run_end;

    modport source (output valid, output code_unit, output final_unit,
                    output out_unit, output run_end, input ready);
    modport sink   (input valid, input code_unit, input final_unit,
                    input out_unit, input run_end, output ready);
endinterface

FILE: hw/rtl/kana_to_romaji_stream.sv
// Top level: kana to romaji stream converter with one-character lookahead.
//
//  channel  | direction | payload                  | beat
//  i_in     | sink      | code_unit, final_unit    | one UTF-16 code unit
//  o_out    | source    | out_unit, run_end        | one romaji letter/copy/end
//
// An accepted beat is converted into a registered queue of up to 7 output
// beats; the queue drains one beat per cycle while o_out is ready. A new beat is
// taken when the queue will be empty after this cycle's output, so the output
// register decides the rate.
// Reset (synchronous, active low) clears the held character and the queue.
// Output stalls hold the queue; input stalls leave the output draining.
module kana_to_romaji_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    k2r_stream_if.sink   i_in,
    k2r_stream_if.source o_out
);
    localparam int QD = 7;

    logic [15:0]       r_held, n_held;
    logic              r_hv, n_hv;
    logic [15:0]       r_q [QD];
    logic              r_qe [QD];
    logic [15:0]       n_q [QD];
    logic              n_qe [QD];
    logic [2:0]        r_cnt, n_cnt;
    logic [2:0]        r_rd, n_rd;
    logic              take, pop, drain_last;
    logic [15:0]       mid_char;
    logic              mid_valid;
    k2r_pkg::t_chunk   c1, c2;
    logic [2:0]        wp;

    // First conversion: held char against the new unit
    k2r_chunk u_c1 (.i_first(r_held), .i_next(i_in.code_unit), .o_chunk(c1));
    // Flush conversion at the end of a string
    k2r_chunk u_c2 (.i_first(mid_char), .i_next(16'h0000), .o_chunk(c2));

    assign pop        = (r_cnt != 3'd0) && o_out.ready;
    assign drain_last = (r_cnt == 3'd0) || (pop && (r_rd + 3'd1 == r_cnt));
    assign i_in.ready = drain_last;
    assign take       = i_in.valid && i_in.ready;

    assign o_out.valid      = (r_cnt != 3'd0);
    assign o_out.out_unit   = r_q[r_rd];
    assign o_out.run_end    = r_qe[r_rd];
    assign o_out.code_unit  = 16'h0000;
    assign o_out.final_unit = 1'b0;

    // Held state after the normal step
    always_comb begin
        mid_char  = i_in.code_unit;
        mid_valid = 1'b1;
        if (r_hv && !c1.copy && c1.pair) mid_valid = 1'b0;
    end

    // Build next queue contents
    always_comb begin
        n_held = r_held;
        n_hv   = r_hv;
        n_q    = r_q;
        n_qe   = r_qe;
        n_cnt  = r_cnt;
        n_rd   = r_rd;
        wp     = 3'd0;
        if (pop) begin
            n_rd = r_rd + 3'd1;
            if (r_rd + 3'd1 == r_cnt) begin
                n_cnt = 3'd0;
                n_rd  = 3'd0;
            end
        end
        if (take) begin
            for (int k = 0; k < QD; k++) n_qe[k] = 1'b0;
            n_rd = 3'd0;
            if (r_hv) begin
                if (c1.copy) begin
                    n_q[wp] = r_held; wp = wp + 3'd1;
                end else begin
                    // long-vowel mark converts to no letters at all
                    if (c1.cnt > 3'd0) begin n_q[wp] = {8'h00, c1.c0}; wp = wp + 3'd1; end
                    if (c1.cnt > 3'd1) begin n_q[wp] = {8'h00, c1.c1}; wp = wp + 3'd1; end
                    if (c1.cnt > 3'd2) begin n_q[wp] = {8'h00, c1.c2}; wp = wp + 3'd1; end
                end
            end
            n_held = mid_char;
            n_hv   = mid_valid;
            if (i_in.final_unit) begin
                if (mid_valid) begin
                    if (c2.copy) begin
                        n_q[wp] = mid_char; wp = wp + 3'd1;
                    end else begin
                        if (c2.cnt > 3'd0) begin n_q[wp] = {8'h00, c2.c0}; wp = wp + 3'd1; end
                        if (c2.cnt > 3'd1) begin n_q[wp] = {8'h00, c2.c1}; wp = wp + 3'd1; end
                        if (c2.cnt > 3'd2) begin n_q[wp] = {8'h00, c2.c2}; wp = wp + 3'd1; end
                    end
                end
                n_q[wp]  = 16'h0000;
                n_qe[wp] = 1'b1;
                wp       = wp + 3'd1;
                n_hv     = 1'b0;
            end
            n_cnt = wp;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= 1'b0;
            r_held <= 16'h0000;
            r_cnt  <= 3'd0;
            r_rd   <= 3'd0;
        end else begin
            r_hv   <= n_hv;
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_rd   <= n_rd;
        end
    end

    // Output queue payload
    always_ff @(posedge i_clk) begin
        r_q  <= n_q;
        r_qe <= n_qe;
    end
endmodule

FILE: hw/rtl/k2r_chunk.sv
// Converts one held character against its lookahead into up to three letters.
module k2r_chunk (
    input  logic [15:0]     i_first,
    input  logic [15:0]     i_next,
    output k2r_pkg::t_chunk o_chunk
);
    logic [15:0]       a;
    logic [15:0]       b;
    k2r_pkg::t_single  s_a;
    k2r_pkg::t_single  s_b;
    k2r_pkg::t_single  p_ab;
    logic              b_vowel;

    assign a    = k2r_pkg::fold(i_first);
    assign b    = k2r_pkg::fold(i_next);
    assign s_a  = k2r_pkg::single_rom(a);
    assign s_b  = k2r_pkg::single_rom(b);
    assign p_ab = k2r_pkg::pair_rom(a, b);
    assign b_vowel = (s_b.rom.c0 == "a") || (s_b.rom.c0 == "e") || (s_b.rom.c0 == "i")
                  || (s_b.rom.c0 == "o") || (s_b.rom.c0 == "u");

    // Priority: out of range, small tsu, digraph, single, copy
    always_comb begin
        o_chunk = '0;
        o_chunk.cnt  = 3'd1;
        o_chunk.copy = 1'b1;
        if (a < k2r_pkg::KANA_LO || a > k2r_pkg::KANA_HI || a == k2r_pkg::MIDDOT) begin
            o_chunk.copy = 1'b1;
        end else if (a == k2r_pkg::SMALL_TSU) begin
            if (s_b.hit && s_b.rom.len != 2'd0 && !b_vowel) begin
                o_chunk.copy = 1'b0;
                o_chunk.c0   = s_b.rom.c0;
            end
        end else if (p_ab.hit) begin
            o_chunk.copy = 1'b0;
            o_chunk.pair = 1'b1;
            o_chunk.cnt  = {1'b0, p_ab.rom.len};
            o_chunk.c0   = p_ab.rom.c0;
            o_chunk.c1   = p_ab.rom.c1;
            o_chunk.c2   = p_ab.rom.c2;
        end else if (s_a.hit) begin
            o_chunk.copy = 1'b0;
            o_chunk.cnt  = {1'b0, s_a.rom.len};
            o_chunk.c0   = s_a.rom.c0;
            o_chunk.c1   = s_a.rom.c1;
            o_chunk.c2   = s_a.rom.c2;
        end
    end
endmodule
